[src/bps_pkg.sv]
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer package
// Shared widths, command, mode and register index codes, the item and result
// types and register reset values for the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bps_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W       = 3;
    localparam int COUNT_W     = 8;
    localparam int DUR_W       = 16;
    localparam int MODE_W      = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Default internal time width
    localparam int TIME_WIDTH_DEF = 16;

    // Register reset values, in ms
    localparam logic [CFG_DATA_W-1:0] ALARM_ON_RESET  = 16'd100;
    localparam logic [CFG_DATA_W-1:0] ALARM_OFF_RESET = 16'd900;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK          = 3'd0,
        CMD_ON            = 3'd1,
        CMD_OFF           = 3'd2,
        CMD_BEEP          = 3'd3,
        CMD_BEEP_COUNT    = 3'd4,
        CMD_ALARM_DEFAULT = 3'd5,
        CMD_ALARM_STOP    = 3'd6,
        CMD_ALARM_PATTERN = 3'd7
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE  = 3'd0,
        MODE_ON    = 3'd1,
        MODE_BEEP  = 3'd2,
        MODE_COUNT = 3'd3,
        MODE_ALARM = 3'd4
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALARM_ON  = 2'd0,
        REG_ALARM_OFF = 2'd1
    } t_reg_index;

    typedef struct packed {
        t_cmd               cmd;
        logic [COUNT_W-1:0] beep_count;
        logic [DUR_W-1:0]   on_time;
        logic [DUR_W-1:0]   off_time;
    } t_item;

    typedef struct packed {
        logic  buzzer_active;
        t_mode mode;
    } t_result;

endpackage

[src/bps_item_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command or tick transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bps_item_if;
    logic                        valid;
    logic                        ready;
    logic [bps_pkg::CMD_W-1:0]   cmd;
    logic [bps_pkg::COUNT_W-1:0] beep_count;
    logic [bps_pkg::DUR_W-1:0]   on_time;
    logic [bps_pkg::DUR_W-1:0]   off_time;

    modport source (output valid, cmd, beep_count, on_time, off_time, input ready);
    modport sink   (input valid, cmd, beep_count, on_time, off_time, output ready);
endinterface

[src/bps_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the buzzer state after each command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bps_result_if;
    logic                       valid;
    logic                       ready;
    logic                       buzzer_active;
    logic [bps_pkg::MODE_W-1:0] mode;

    modport source (output valid, buzzer_active, mode, input ready);
    modport sink   (input valid, buzzer_active, mode, output ready);
endinterface

[src/bps_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bps_pkg::CFG_INDEX_W-1:0] index;
    logic [bps_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/bps_core.sv]
// ----------------------------------------------------------------------------
// Buzzer sequencer core
// Holds the mode, phase, beep count, countdown and saved pattern, and applies
// one command or tick per advance. Gives the state after the transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bps_core #(
    parameter int TIME_WIDTH = bps_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  bps_pkg::t_item                i_item,
    input  logic [bps_pkg::CFG_DATA_W-1:0] i_alarm_on,
    input  logic [bps_pkg::CFG_DATA_W-1:0] i_alarm_off,
    output bps_pkg::t_result              o_result
);
    import bps_pkg::*;

    localparam int WIDE_W = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

    // Saturate a 16-bit duration to the internal time width
    function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [DUR_W-1:0] v);
        logic [WIDE_W-1:0] ext;
        logic [WIDE_W-1:0] top;
        ext = WIDE_W'(v);
        top = WIDE_W'({TIME_WIDTH{1'b1}});
        if (ext > top) begin
            return {TIME_WIDTH{1'b1}};
        end
        return ext[TIME_WIDTH-1:0];
    endfunction

    t_mode                 r_mode,      n_mode;
    logic [COUNT_W-1:0]    r_beeps,     n_beeps;
    logic                  r_sounding,  n_sounding;
    logic [TIME_WIDTH-1:0] r_countdown, n_countdown;
    logic [TIME_WIDTH-1:0] r_saved_on,  n_saved_on;
    logic [TIME_WIDTH-1:0] r_saved_off, n_saved_off;

    logic [TIME_WIDTH-1:0] w_on_t;
    logic [TIME_WIDTH-1:0] w_off_t;
    logic [TIME_WIDTH-1:0] w_pat_on;
    logic [TIME_WIDTH-1:0] w_pat_off;
    logic [TIME_WIDTH-1:0] w_cd_dec;
    logic                  w_expired;
    logic [COUNT_W-1:0]    w_beeps_dec;

    // Saturate the durations and pick the alarm pattern source
    always_comb begin
        w_on_t    = sat_time(i_item.on_time);
        w_off_t   = sat_time(i_item.off_time);
        w_pat_on  = (i_item.cmd == CMD_ALARM_DEFAULT) ? sat_time(i_alarm_on)  : w_on_t;
        w_pat_off = (i_item.cmd == CMD_ALARM_DEFAULT) ? sat_time(i_alarm_off) : w_off_t;
        w_cd_dec  = (r_countdown != '0) ? r_countdown - TIME_WIDTH'(1) : '0;
        w_expired = (w_cd_dec == '0);
        w_beeps_dec = (r_beeps != '0) ? r_beeps - COUNT_W'(1) : '0;
    end

    // Next state for one transaction
    always_comb begin
        n_mode      = r_mode;
        n_beeps     = r_beeps;
        n_sounding  = r_sounding;
        n_countdown = r_countdown;
        n_saved_on  = r_saved_on;
        n_saved_off = r_saved_off;
        case (i_item.cmd)
            CMD_TICK: begin
                case (r_mode)
                    MODE_BEEP: begin
                        n_countdown = w_cd_dec;
                        if (w_expired) begin
                            n_mode      = MODE_IDLE;
                            n_beeps     = '0;
                            n_sounding  = 1'b0;
                            n_countdown = '0;
                            n_saved_on  = '0;
                            n_saved_off = '0;
                        end
                    end
                    MODE_COUNT: begin
                        n_countdown = w_cd_dec;
                        if (w_expired) begin
                            if (r_sounding) begin
                                n_beeps    = w_beeps_dec;
                                n_sounding = 1'b0;
                                if (w_beeps_dec == '0) begin
                                    n_mode = MODE_IDLE;
                                end else begin
                                    n_countdown = r_saved_off;
                                end
                            end else begin
                                n_sounding  = 1'b1;
                                n_countdown = r_saved_on;
                            end
                        end
                    end
                    MODE_ALARM: begin
                        n_countdown = w_cd_dec;
                        if (w_expired) begin
                            n_sounding  = ~r_sounding;
                            n_countdown = r_sounding ? r_saved_off : r_saved_on;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_ON: begin
                n_mode     = MODE_ON;
                n_beeps    = '0;
                n_sounding = 1'b1;
            end
            CMD_BEEP: begin
                if (w_on_t == '0) begin
                    n_mode      = MODE_IDLE;
                    n_beeps     = '0;
                    n_sounding  = 1'b0;
                    n_countdown = '0;
                    n_saved_on  = '0;
                    n_saved_off = '0;
                end else begin
                    n_mode      = MODE_BEEP;
                    n_beeps     = '0;
                    n_sounding  = 1'b1;
                    n_countdown = w_on_t;
                end
            end
            CMD_BEEP_COUNT: begin
                if (i_item.beep_count == '0 || w_on_t == '0) begin
                    n_mode      = MODE_IDLE;
                    n_beeps     = '0;
                    n_sounding  = 1'b0;
                    n_countdown = '0;
                    n_saved_on  = '0;
                    n_saved_off = '0;
                end else begin
                    n_mode      = MODE_COUNT;
                    n_beeps     = i_item.beep_count;
                    n_sounding  = 1'b1;
                    n_saved_on  = w_on_t;
                    n_saved_off = w_off_t;
                    n_countdown = w_on_t;
                end
            end
            CMD_ALARM_DEFAULT, CMD_ALARM_PATTERN: begin
                if (w_pat_on == '0 || w_pat_off == '0) begin
                    // Zero pattern stops a running alarm only
                    if (r_mode == MODE_ALARM) begin
                        n_mode      = MODE_IDLE;
                        n_beeps     = '0;
                        n_sounding  = 1'b0;
                        n_countdown = '0;
                        n_saved_on  = '0;
                        n_saved_off = '0;
                    end
                end else if (!(r_mode == MODE_ALARM && r_saved_on == w_pat_on
                               && r_saved_off == w_pat_off)) begin
                    n_mode      = MODE_ALARM;
                    n_sounding  = 1'b1;
                    n_saved_on  = w_pat_on;
                    n_saved_off = w_pat_off;
                    n_countdown = w_pat_on;
                end
            end
            CMD_ALARM_STOP: begin
                if (r_mode == MODE_ALARM) begin
                    n_mode      = MODE_IDLE;
                    n_beeps     = '0;
                    n_sounding  = 1'b0;
                    n_countdown = '0;
                    n_saved_on  = '0;
                    n_saved_off = '0;
                end
            end
            default: begin
                // Off: drop everything back to idle
                n_mode      = MODE_IDLE;
                n_beeps     = '0;
                n_sounding  = 1'b0;
                n_countdown = '0;
                n_saved_on  = '0;
                n_saved_off = '0;
            end
        endcase
    end

    // Hold the sequencer state, advance once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_beeps     <= '0;
            r_sounding  <= 1'b0;
            r_countdown <= '0;
            r_saved_on  <= '0;
            r_saved_off <= '0;
        end else if (i_advance) begin
            r_mode      <= n_mode;
            r_beeps     <= n_beeps;
            r_sounding  <= n_sounding;
            r_countdown <= n_countdown;
            r_saved_on  <= n_saved_on;
            r_saved_off <= n_saved_off;
        end
    end

    assign o_result.buzzer_active = n_sounding;
    assign o_result.mode          = n_mode;

endmodule

[src/buzzer_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer
// Path: a taken command is held in the input register, then its state update
// is registered into the result register, which presents the result.
// Throughput: one transaction per cycle while the result side is ready.
// Reset: synchronous active low; returns to idle, silent, with the alarm
// registers at 100 ms on and 900 ms off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buzzer_pattern_sequencer #(
    parameter int TIME_WIDTH = bps_pkg::TIME_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bps_item_if.sink      i_item,
    bps_cfg_if.sink       i_cfg,
    bps_result_if.source  o_result
);
    import bps_pkg::*;

    logic                  r_in_valid;
    t_item                 r_in;
    logic                  r_out_valid;
    t_result               r_out;
    logic [CFG_DATA_W-1:0] r_alarm_on;
    logic [CFG_DATA_W-1:0] r_alarm_off;

    logic                  w_advance;
    t_result               w_next;

    // Move the held command on whenever the result register is free
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;
    assign i_cfg.ready  = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.cmd        <= t_cmd'(i_item.cmd);
            r_in.beep_count <= i_item.beep_count;
            r_in.on_time    <= i_item.on_time;
            r_in.off_time   <= i_item.off_time;
        end
    end

    // Alarm pattern registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_on  <= ALARM_ON_RESET;
            r_alarm_off <= ALARM_OFF_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_index'(i_cfg.index))
                REG_ALARM_ON:  r_alarm_on  <= i_cfg.data;
                REG_ALARM_OFF: r_alarm_off <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    bps_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_item      (r_in),
        .i_alarm_on  (r_alarm_on),
        .i_alarm_off (r_alarm_off),
        .o_result    (w_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_next;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.buzzer_active = r_out.buzzer_active;
    assign o_result.mode          = r_out.mode;

`ifndef SYNTHESIS
    // Steady on and single beep always sound
    a_on_sounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.mode == MODE_ON || o_result.mode == MODE_BEEP))
        |-> o_result.buzzer_active)
        else $error("buzzer silent in a sounding mode");

    // Idle never sounds
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.mode == MODE_IDLE) |-> !o_result.buzzer_active)
        else $error("buzzer sounding while idle");

    // A taken command is held for processing
    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_in_valid)
        else $error("command transaction lost");

    // A processed command always leaves a result
    a_result_made: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result transaction lost");
`endif

endmodule

[sim/buzzer_pattern_sequencer_test.sv]
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer testbench
// Feeds command and tick transactions through a queued driver with random
// gaps and collects results through a monitor with random stalls. Each result
// is checked against a cycle-free model of the sequencer kept here, through
// several alarm register settings, one long result stall and a few drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buzzer_pattern_sequencer_test;

    import bps_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 12;
    localparam int MAX_WAIT         = 12;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_SETTLE     = 4;
    localparam int CYCLE_LIMIT      = 400000;

    // Register indexes that map to no register
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Testbench-side drives of the channels
    logic                   cmd_valid    = 1'b0;
    t_item                  cmd_word     = '0;
    logic                   result_ready = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    logic results_held = 1'b0;
    logic idling_on    = 1'b1;
    event long_hold_go;

    t_item   pending_cmds[$];
    t_result expected_states[$];
    int      mismatch_count = 0;
    int      send_gap       = 0;
    int      recv_stall     = 0;
    int      cycle_count    = 0;

    // Model of the sequencer state and its alarm registers
    t_mode                 seq_mode;
    logic [COUNT_W-1:0]    seq_beeps_left;
    logic                  seq_sounding;
    logic [DUR_W-1:0]      seq_countdown;
    logic [DUR_W-1:0]      seq_on_saved;
    logic [DUR_W-1:0]      seq_off_saved;
    logic [CFG_DATA_W-1:0] reg_alarm_on;
    logic [CFG_DATA_W-1:0] reg_alarm_off;

    bps_item_if   cmd_ch ();
    bps_cfg_if    cfg_ch ();
    bps_result_if res_ch ();

    assign cmd_ch.valid      = cmd_valid;
    assign cmd_ch.cmd        = cmd_word.cmd;
    assign cmd_ch.beep_count = cmd_word.beep_count;
    assign cmd_ch.on_time    = cmd_word.on_time;
    assign cmd_ch.off_time   = cmd_word.off_time;
    assign res_ch.ready      = result_ready;
    assign cfg_ch.valid      = cfg_valid;
    assign cfg_ch.index      = cfg_index;
    assign cfg_ch.data       = cfg_data;

    buzzer_pattern_sequencer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (cmd_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Drop to idle, silent, with all times cleared
    function automatic void silence_all();
        seq_mode       = MODE_IDLE;
        seq_beeps_left = '0;
        seq_sounding   = 1'b0;
        seq_countdown  = '0;
        seq_on_saved   = '0;
        seq_off_saved  = '0;
    endfunction

    // Start an alarm; a zero time stops a running alarm, a repeat is ignored.
    // With 16-bit time the durations need no saturation.
    function automatic void request_alarm(logic [DUR_W-1:0] on_t, logic [DUR_W-1:0] off_t);
        if (on_t == '0 || off_t == '0) begin
            if (seq_mode == MODE_ALARM)
                silence_all();
        end else if (!(seq_mode == MODE_ALARM && seq_on_saved == on_t
                       && seq_off_saved == off_t)) begin
            seq_mode      = MODE_ALARM;
            seq_sounding  = 1'b1;
            seq_on_saved  = on_t;
            seq_off_saved = off_t;
            seq_countdown = on_t;
        end
    endfunction

    // Count one tick down; report whether the phase has run out
    function automatic logic phase_over();
        if (seq_countdown != '0)
            seq_countdown = seq_countdown - DUR_W'(1);
        return seq_countdown == '0;
    endfunction

    // Apply one transaction to the model and return the buzzer state after it
    function automatic t_result predict_buzzer(t_item it);
        t_result res;
        case (it.cmd)
            CMD_TICK: begin
                case (seq_mode)
                    MODE_BEEP: begin
                        if (phase_over())
                            silence_all();
                    end
                    MODE_COUNT: begin
                        if (phase_over()) begin
                            if (seq_sounding) begin
                                if (seq_beeps_left != '0)
                                    seq_beeps_left = seq_beeps_left - COUNT_W'(1);
                                seq_sounding = 1'b0;
                                // last beep finished: idle, keep the saved times
                                if (seq_beeps_left == '0)
                                    seq_mode = MODE_IDLE;
                                else
                                    seq_countdown = seq_off_saved;
                            end else begin
                                seq_sounding  = 1'b1;
                                seq_countdown = seq_on_saved;
                            end
                        end
                    end
                    MODE_ALARM: begin
                        if (phase_over()) begin
                            seq_sounding  = !seq_sounding;
                            seq_countdown = seq_sounding ? seq_on_saved : seq_off_saved;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_ON: begin
                seq_mode       = MODE_ON;
                seq_beeps_left = '0;
                seq_sounding   = 1'b1;
            end
            CMD_OFF: silence_all();
            CMD_BEEP: begin
                if (it.on_time == '0) begin
                    silence_all();
                end else begin
                    seq_mode       = MODE_BEEP;
                    seq_beeps_left = '0;
                    seq_sounding   = 1'b1;
                    seq_countdown  = it.on_time;
                end
            end
            CMD_BEEP_COUNT: begin
                if (it.beep_count == '0 || it.on_time == '0) begin
                    silence_all();
                end else begin
                    seq_mode       = MODE_COUNT;
                    seq_beeps_left = it.beep_count;
                    seq_sounding   = 1'b1;
                    seq_on_saved   = it.on_time;
                    seq_off_saved  = it.off_time;
                    seq_countdown  = it.on_time;
                end
            end
            CMD_ALARM_DEFAULT: request_alarm(reg_alarm_on, reg_alarm_off);
            CMD_ALARM_STOP: begin
                if (seq_mode == MODE_ALARM)
                    silence_all();
            end
            default: request_alarm(it.on_time, it.off_time);
        endcase
        res.buzzer_active = seq_sounding;
        res.mode          = seq_mode;
        return res;
    endfunction

    function automatic int draw_wait();
        return idling_on ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // Mostly short durations so that phases run out, with zero and extremes
    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        else if (r < 80)
            return DUR_W'($urandom_range(1, 6));
        else if (r < 90)
            return DUR_W'($urandom_range(7, 40));
        else if (r < 95)
            return '1;
        return DUR_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_register_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd1;
        else if (r == 1)
            return '1;
        else if (r == 9)
            return '0;
        else if (r < 7)
            return CFG_DATA_W'($urandom_range(1, 6));
        return CFG_DATA_W'($urandom);
    endfunction

    function automatic void queue_item(t_cmd c, logic [COUNT_W-1:0] cnt,
                                       logic [DUR_W-1:0] on_t, logic [DUR_W-1:0] off_t);
        t_item it;
        it.cmd        = c;
        it.beep_count = cnt;
        it.on_time    = on_t;
        it.off_time   = off_t;
        pending_cmds.push_back(it);
    endfunction

    // Queue commands, each followed by a run of ticks with random payload
    task automatic queue_random_run(int n);
        int               made;
        int               r;
        logic [DUR_W-1:0] on_t;
        logic [DUR_W-1:0] off_t;
        logic [DUR_W-1:0] last_on;
        logic [DUR_W-1:0] last_off;
        made     = 0;
        last_on  = 16'd2;
        last_off = 16'd3;
        while (made < n) begin
            r     = $urandom_range(0, 99);
            on_t  = pick_duration();
            off_t = pick_duration();
            if (r < 30) begin
                queue_item(CMD_BEEP_COUNT,
                           COUNT_W'(($urandom_range(0, 9) == 0) ? $urandom
                                                                 : $urandom_range(0, 4)),
                           on_t, off_t);
            end else if (r < 45) begin
                // now and then resend the pattern that may still be running
                if ($urandom_range(0, 3) == 0) begin
                    on_t  = last_on;
                    off_t = last_off;
                end
                last_on  = on_t;
                last_off = off_t;
                queue_item(CMD_ALARM_PATTERN, COUNT_W'($urandom), on_t, off_t);
            end else if (r < 55) begin
                queue_item(CMD_ALARM_DEFAULT, COUNT_W'($urandom), DUR_W'($urandom),
                           DUR_W'($urandom));
            end else if (r < 67) begin
                queue_item(CMD_BEEP, COUNT_W'($urandom), on_t, off_t);
            end else if (r < 74) begin
                queue_item(CMD_ON, COUNT_W'($urandom), DUR_W'($urandom), DUR_W'($urandom));
            end else if (r < 80) begin
                queue_item(CMD_OFF, COUNT_W'($urandom), DUR_W'($urandom), DUR_W'($urandom));
            end else if (r < 86) begin
                queue_item(CMD_ALARM_STOP, COUNT_W'($urandom), DUR_W'($urandom),
                           DUR_W'($urandom));
            end else begin
                queue_item(t_cmd'($urandom_range(0, 7)), COUNT_W'($urandom), on_t, off_t);
            end
            made++;
            repeat ($urandom_range(0, 25)) begin
                queue_item(CMD_TICK, COUNT_W'($urandom), DUR_W'($urandom), DUR_W'($urandom));
                made++;
            end
        end
    endtask

    // Hold until every queued transaction has been answered
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_states.size() != 0);
        repeat (DRAIN_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_alarm_register(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_valid <= 1'b0;
        if (idx == REG_ALARM_ON)
            reg_alarm_on = value;
        else if (idx == REG_ALARM_OFF)
            reg_alarm_off = value;
        @(negedge i_clk);
    endtask

    // Driver: present queued transactions, predict each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (cmd_valid && cmd_ch.ready)
                expected_states.push_back(predict_buzzer(cmd_word));
            if (!cmd_valid || cmd_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cmd_word  <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    send_gap = draw_wait();
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            result_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_states.size() == 0) begin
                    $error("unexpected result: buzzer_active %0d, mode %0d",
                           res_ch.buzzer_active, res_ch.mode);
                    mismatch_count++;
                end else begin
                    want = expected_states.pop_front();
                    if (res_ch.buzzer_active !== want.buzzer_active) begin
                        $error("buzzer_active mismatch: expected %0d, actual %0d",
                               want.buzzer_active, res_ch.buzzer_active);
                        mismatch_count++;
                    end
                    if (res_ch.mode !== want.mode) begin
                        $error("mode mismatch: expected %0d, actual %0d",
                               want.mode, res_ch.mode);
                        mismatch_count++;
                    end
                end
                recv_stall = draw_wait();
            end else if (recv_stall != 0) begin
                recv_stall--;
            end
            result_ready <= (recv_stall == 0) && !results_held;
        end
    end

    // Long result stall, counted here while the driver keeps offering
    always begin
        @(long_hold_go);
        results_held <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        results_held <= 1'b0;
    end

    // Cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        silence_all();
        reg_alarm_on  = ALARM_ON_RESET;
        reg_alarm_off = ALARM_OFF_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: edges of every command at the reset register values
        queue_item(CMD_TICK, '1, '1, '1);
        queue_item(CMD_ON, '0, '0, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_BEEP, '0, '0, '1);
        queue_item(CMD_BEEP, '0, 16'd2, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_BEEP_COUNT, '0, 16'd5, 16'd5);
        queue_item(CMD_BEEP_COUNT, 8'd2, '0, 16'd5);
        // silent gap of zero lasts one tick
        queue_item(CMD_BEEP_COUNT, 8'd2, 16'd1, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_BEEP_COUNT, '1, '1, '1);
        queue_item(CMD_ALARM_STOP, '0, '0, '0);
        queue_item(CMD_OFF, '0, '0, '0);
        queue_item(CMD_ALARM_PATTERN, '0, '0, 16'd5);
        queue_item(CMD_ALARM_PATTERN, '0, 16'd2, 16'd1);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_ALARM_PATTERN, '0, 16'd2, 16'd1);
        queue_item(CMD_ALARM_PATTERN, '0, 16'd2, '0);
        queue_item(CMD_ALARM_DEFAULT, '0, '0, '0);
        queue_item(CMD_ALARM_STOP, '0, '0, '0);
        wait_drained();

        // Short default alarm, then resend it unchanged
        write_alarm_register(REG_ALARM_ON, 16'd2);
        write_alarm_register(REG_ALARM_OFF, 16'd3);
        queue_item(CMD_ALARM_DEFAULT, '0, '0, '0);
        repeat (4) queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_ALARM_DEFAULT, '0, '0, '0);
        wait_drained();

        // Zero register while the alarm runs stops it; when idle it does nothing
        write_alarm_register(REG_ALARM_ON, '0);
        queue_item(CMD_ALARM_DEFAULT, '0, '0, '0);
        queue_item(CMD_ALARM_DEFAULT, '0, '0, '0);
        wait_drained();

        // Spare indexes are ignored; then extreme register values
        write_alarm_register(REG_SPARE_LO, '1);
        write_alarm_register(REG_SPARE_HI, '0);
        write_alarm_register(REG_ALARM_ON, 16'd1);
        write_alarm_register(REG_ALARM_OFF, '1);
        queue_item(CMD_ALARM_DEFAULT, '0, '0, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_TICK, '0, '0, '0);
        queue_item(CMD_ALARM_PATTERN, '0, 16'd1, '1);
        queue_item(CMD_ALARM_STOP, '0, '0, '0);
        wait_drained();
        write_alarm_register(REG_ALARM_ON, '1);
        write_alarm_register(REG_ALARM_OFF, 16'd1);

        // Random phases, each with its own register setting
        for (int p = 0; p < 7; p++) begin
            if (p != 0) begin
                write_alarm_register(REG_ALARM_ON, pick_register_value());
                write_alarm_register(REG_ALARM_OFF, pick_register_value());
            end
            if (p == 2) begin
                // back-to-back offers against a long result stall
                idling_on = 1'b0;
                queue_random_run(80);
                -> long_hold_go;
                wait_drained();
                idling_on = 1'b1;
            end
            queue_random_run(120);
            if (p == 4)
                wait_drained();
            queue_random_run(70);
            wait_drained();
        end

        repeat (DRAIN_SETTLE) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
